// File: hw/rtl/adcsfa_pkg.sv
// Package for the ADC scan frame assembler.
// Holds field widths, register indexes, reset values and scan limits.
// No dependencies.
package adcsfa_pkg;

  localparam int unsigned MAX_LANES   = 4;
  localparam int unsigned MAX_SLOTS   = 64;
  localparam int unsigned SELECT_REGS = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam int unsigned LANE_CNT_W = 3;
  localparam int unsigned SLOTS_W    = 7;
  localparam int unsigned SELECT_W   = 5;
  localparam int unsigned LANE_W     = 2;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned CHANNEL_W  = 4;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned VALUE_W    = 12;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned SEQ_W      = 32;

  // Input tdata: unit, channel, raw, time; padded to whole bytes.
  localparam int unsigned IN_DATA_BITS = 1 + CHANNEL_W + RAW_W + TIME_W;
  localparam int unsigned IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  // Output tdata: lane, slot, value, sequence, time; padded to whole bytes.
  localparam int unsigned OUT_DATA_BITS = LANE_W + SLOT_W + VALUE_W + SEQ_W + TIME_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LANE0_SEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANE1_SEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LANE2_SEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LANE3_SEL  = 3'd5;

  localparam logic [LANE_CNT_W-1:0] LANE_COUNT_RESET = 3'd1;
  localparam logic [SLOTS_W-1:0]    SLOTS_RESET      = 7'd50;
  localparam logic [SELECT_W-1:0]   LANE0_SEL_RESET  = 5'd6;
  localparam logic [SELECT_W-1:0]   LANE1_SEL_RESET  = 5'd3;
  localparam logic [SELECT_W-1:0]   LANE2_SEL_RESET  = 5'd0;
  localparam logic [SELECT_W-1:0]   LANE3_SEL_RESET  = 5'd1;

  // Lane limit as a lane count, and slot limit as a slot count.
  localparam logic [LANE_CNT_W-1:0] LANE_LIMIT =
      (MAX_LANES < SELECT_REGS) ? LANE_CNT_W'(MAX_LANES) : LANE_CNT_W'(SELECT_REGS);
  localparam logic [SLOTS_W-1:0] SLOT_LIMIT =
      (MAX_SLOTS < (1 << SLOTS_W)) ? SLOTS_W'(MAX_SLOTS) : {SLOTS_W{1'b1}};

  typedef logic [SELECT_W-1:0] lane_select_t [SELECT_REGS];

endpackage

// File: hw/rtl/adc_scan_frame_assembler_top.sv
// Top level of the ADC scan frame assembler: lane mapping, frame tracking
// and the output register. Depends on adcsfa_pkg.
//
// The block takes one converter result per cycle and returns at most one
// sample item for it through an output register; input ready stays high while
// that register is empty or being drained, so with m_tready high results
// stream at one item per clock with no gaps. Invalid results, results whose
// unit and channel match no lane in use, and results that arrive while no
// frame is open or that break lane order without being lane 0 produce no
// item. Each item carries the lane, slot, centred value, the frame's start
// time, tuser set when it opens a frame, and tlast with the sequence number
// when it completes one. Configuration should only be written while idle.
module adc_scan_frame_assembler_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [adcsfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adcsfa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // Fields from bit 0: adc_unit, adc_channel, raw_sample, now_us.
  input  logic [adcsfa_pkg::IN_DATA_W-1:0]      s_tdata,
  // Field: sample_ok.
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // Fields from bit 0: lane_index, slot_index, centred_value,
  // frame_sequence, frame_time_us.
  output logic [adcsfa_pkg::OUT_DATA_W-1:0]     m_tdata,
  // Field: frame_begin.
  output logic                                  m_tuser,
  // Field: frame_done.
  output logic                                  m_tlast
);
  import adcsfa_pkg::*;

  logic [LANE_CNT_W-1:0] lane_count;
  logic [SLOTS_W-1:0]    slots;
  lane_select_t          lane_sel;

  logic                  assembling, assembling_next;
  logic [LANE_W-1:0]     expected_lane, expected_lane_next;
  logic [SLOTS_W-1:0]    fill_slot, fill_slot_next;
  logic [TIME_W-1:0]     start_time, start_time_next;
  logic [SEQ_W-1:0]      last_sequence, last_sequence_next;

  logic                  in_unit;
  logic [CHANNEL_W-1:0]  in_channel;
  logic [RAW_W-1:0]      in_raw;
  logic [TIME_W-1:0]     in_time;
  logic [SELECT_W-1:0]   key;

  logic [LANE_CNT_W-1:0] lanes_in_use;
  logic [SLOTS_W-1:0]    slots_in_use;
  logic                  hit;
  logic [LANE_W-1:0]     lane;

  logic                  emit;
  logic                  begin_flag;
  logic                  done_flag;
  logic [SEQ_W-1:0]      seq_out;
  logic [SLOT_W-1:0]     slot_out;
  logic [TIME_W-1:0]     time_out;
  logic [VALUE_W-1:0]    value_out;
  logic                  accept;

  assign in_unit    = s_tdata[0];
  assign in_channel = s_tdata[CHANNEL_W:1];
  assign in_raw     = s_tdata[CHANNEL_W+RAW_W:CHANNEL_W+1];
  assign in_time    = s_tdata[CHANNEL_W+RAW_W+TIME_W:CHANNEL_W+RAW_W+1];
  assign key        = {in_unit, in_channel};

  assign lanes_in_use = (lane_count > LANE_LIMIT) ? LANE_LIMIT : lane_count;
  assign slots_in_use = (slots == '0) ? SLOTS_W'(1) :
                        (slots > SLOT_LIMIT) ? SLOT_LIMIT : slots;

  // Walk down so that the lowest numbered matching lane wins.
  always_comb begin
    hit  = 1'b0;
    lane = '0;
    for (int i = SELECT_REGS - 1; i >= 0; i--) begin
      if ((LANE_CNT_W'(i) < lanes_in_use) && (lane_sel[i] == key)) begin
        hit  = 1'b1;
        lane = LANE_W'(i);
      end
    end
  end

  // Subtracting the midpoint from a 12-bit word is a flip of its top bit.
  assign value_out = {~in_raw[VALUE_W-1], in_raw[VALUE_W-2:0]};

  always_comb begin
    assembling_next    = assembling;
    expected_lane_next = expected_lane;
    fill_slot_next     = fill_slot;
    start_time_next    = start_time;
    last_sequence_next = last_sequence;
    emit               = 1'b0;
    begin_flag         = 1'b0;
    done_flag          = 1'b0;
    seq_out            = '0;
    slot_out           = '0;
    time_out           = start_time;
    if (s_tuser && hit && (assembling || lane == '0)) begin
      emit = 1'b1;
      if (!assembling) begin
        assembling_next    = 1'b1;
        expected_lane_next = '0;
        fill_slot_next     = '0;
        start_time_next    = in_time;
        begin_flag         = 1'b1;
      end
      // Out of order: abort, and reopen at once when the result is lane 0.
      if (lane != expected_lane_next) begin
        expected_lane_next = '0;
        fill_slot_next     = '0;
        if (lane != '0) begin
          assembling_next = 1'b0;
          emit            = 1'b0;
        end else begin
          assembling_next = 1'b1;
          start_time_next = in_time;
          begin_flag      = 1'b1;
        end
      end
      slot_out = fill_slot_next[SLOT_W-1:0];
      time_out = start_time_next;
      if (emit) begin
        if (LANE_CNT_W'(lane) + LANE_CNT_W'(1) == lanes_in_use) begin
          expected_lane_next = '0;
          fill_slot_next     = fill_slot_next + SLOTS_W'(1);
          if (fill_slot_next >= slots_in_use) begin
            last_sequence_next = last_sequence + SEQ_W'(1);
            seq_out            = last_sequence_next;
            done_flag          = 1'b1;
            assembling_next    = 1'b0;
            fill_slot_next     = '0;
            start_time_next    = '0;
          end
        end else begin
          expected_lane_next = expected_lane_next + LANE_W'(1);
        end
      end
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_count  <= LANE_COUNT_RESET;
      slots       <= SLOTS_RESET;
      lane_sel[0] <= LANE0_SEL_RESET;
      lane_sel[1] <= LANE1_SEL_RESET;
      lane_sel[2] <= LANE2_SEL_RESET;
      lane_sel[3] <= LANE3_SEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LANE_COUNT: lane_count  <= cfg_wdata[LANE_CNT_W-1:0];
        REG_SLOTS:      slots       <= cfg_wdata[SLOTS_W-1:0];
        REG_LANE0_SEL:  lane_sel[0] <= cfg_wdata[SELECT_W-1:0];
        REG_LANE1_SEL:  lane_sel[1] <= cfg_wdata[SELECT_W-1:0];
        REG_LANE2_SEL:  lane_sel[2] <= cfg_wdata[SELECT_W-1:0];
        REG_LANE3_SEL:  lane_sel[3] <= cfg_wdata[SELECT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assembling    <= 1'b0;
      expected_lane <= '0;
      fill_slot     <= '0;
      start_time    <= '0;
      last_sequence <= '0;
    end else if (accept) begin
      assembling    <= assembling_next;
      expected_lane <= expected_lane_next;
      fill_slot     <= fill_slot_next;
      start_time    <= start_time_next;
      last_sequence <= last_sequence_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= OUT_DATA_W'({time_out, seq_out, value_out, slot_out, lane});
      m_tuser <= begin_flag;
      m_tlast <= done_flag;
    end
  end

endmodule

// File: verif/adcsfa_frame_checker.sv
// Frame checker for the ADC scan frame assembler: mirrors the configuration
// port, predicts the sample item of every accepted converter result and
// compares the output items in order. Depends on adcsfa_pkg.
module adcsfa_frame_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [adcsfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adcsfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [adcsfa_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                              s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [adcsfa_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                              m_tuser,
  input  logic                              m_tlast,
  output int                                fail_count,
  output int                                outstanding
);
  import adcsfa_pkg::*;

  localparam int unsigned SLOT_LSB  = LANE_W;
  localparam int unsigned VALUE_LSB = SLOT_LSB + SLOT_W;
  localparam int unsigned SEQ_LSB   = VALUE_LSB + VALUE_W;
  localparam int unsigned STAMP_LSB = SEQ_LSB + SEQ_W;

  typedef struct packed {
    logic [LANE_W-1:0]  lane;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               opens;
    logic               closes;
    logic [SEQ_W-1:0]   frame_seq;
    logic [TIME_W-1:0]  stamp;
  } frame_sample_t;

  frame_sample_t expected_samples[$];

  logic [LANE_CNT_W-1:0] cfg_lane_count;
  logic [SLOTS_W-1:0]    cfg_slots;
  logic [SELECT_W-1:0]   cfg_select[SELECT_REGS];

  logic                  assembling;
  logic [LANE_W-1:0]     next_lane;
  logic [SLOTS_W-1:0]    fill_slot;
  logic [TIME_W-1:0]     start_us;
  logic [SEQ_W-1:0]      seq_count;

  int mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Follows the frame state for one accepted converter result and queues the
  // sample item it should produce, if any.
  task automatic track_frame(input logic ok, input logic [IN_DATA_W-1:0] word);
    logic [SELECT_W-1:0] key;
    logic [RAW_W-1:0]    raw;
    logic [TIME_W-1:0]   now;
    int                  lanes;
    int                  slots;
    int                  lane;
    int                  i;
    frame_sample_t       smp;
    key   = {word[0], word[CHANNEL_W:1]};
    raw   = word[CHANNEL_W+1 +: RAW_W];
    now   = word[CHANNEL_W+1+RAW_W +: TIME_W];
    lanes = (cfg_lane_count > MAX_LANES) ? MAX_LANES : cfg_lane_count;
    slots = (cfg_slots == 0) ? 1 : ((cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots);
    lane  = -1;
    // Walk down so that the lowest numbered matching lane wins.
    for (i = lanes - 1; i >= 0; i--) begin
      if (cfg_select[i] == key) lane = i;
    end
    if (!ok || lane < 0) return;
    smp = '0;
    if (!assembling) begin
      if (lane != 0) return;
      assembling = 1'b1;
      fill_slot  = '0;
      next_lane  = '0;
      start_us   = now;
      smp.opens  = 1'b1;
    end
    if (lane != next_lane) begin
      // Out of order: the frame is lost, and only lane 0 can reopen it.
      assembling = 1'b0;
      next_lane  = '0;
      fill_slot  = '0;
      if (lane != 0) return;
      assembling = 1'b1;
      start_us   = now;
      smp.opens  = 1'b1;
    end
    smp.lane  = LANE_W'(lane);
    smp.slot  = fill_slot[SLOT_W-1:0];
    smp.stamp = start_us;
    smp.value = raw[VALUE_W-1:0] - VALUE_W'(2048);
    if (lane + 1 == lanes) begin
      next_lane = '0;
      fill_slot = fill_slot + 1'b1;
      if (fill_slot >= slots) begin
        seq_count     = seq_count + 1'b1;
        smp.frame_seq = seq_count;
        smp.closes    = 1'b1;
        assembling    = 1'b0;
        fill_slot     = '0;
        start_us      = '0;
      end
    end else begin
      next_lane = next_lane + 1'b1;
    end
    expected_samples.push_back(smp);
  endtask

  task automatic check_sample();
    frame_sample_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch("output item with no expected sample");
      return;
    end
    want = expected_samples.pop_front();
    compare_field("lane_index", m_tdata[0 +: LANE_W], want.lane);
    compare_field("slot_index", m_tdata[SLOT_LSB +: SLOT_W], want.slot);
    compare_field("centred_value", m_tdata[VALUE_LSB +: VALUE_W], want.value);
    compare_field("frame_sequence", m_tdata[SEQ_LSB +: SEQ_W], want.frame_seq);
    compare_field("frame_time_us", m_tdata[STAMP_LSB +: TIME_W], want.stamp);
    compare_field("frame_begin", m_tuser, want.opens);
    compare_field("frame_done", m_tlast, want.closes);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_lane_count = LANE_COUNT_RESET;
      cfg_slots      = SLOTS_RESET;
      cfg_select[0]  = LANE0_SEL_RESET;
      cfg_select[1]  = LANE1_SEL_RESET;
      cfg_select[2]  = LANE2_SEL_RESET;
      cfg_select[3]  = LANE3_SEL_RESET;
      assembling     = 1'b0;
      next_lane      = '0;
      fill_slot      = '0;
      start_us       = '0;
      seq_count      = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LANE_COUNT: cfg_lane_count = cfg_wdata[LANE_CNT_W-1:0];
          REG_SLOTS:      cfg_slots      = cfg_wdata[SLOTS_W-1:0];
          REG_LANE0_SEL:  cfg_select[0]  = cfg_wdata[SELECT_W-1:0];
          REG_LANE1_SEL:  cfg_select[1]  = cfg_wdata[SELECT_W-1:0];
          REG_LANE2_SEL:  cfg_select[2]  = cfg_wdata[SELECT_W-1:0];
          REG_LANE3_SEL:  cfg_select[3]  = cfg_wdata[SELECT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) track_frame(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_sample();
    end
    outstanding = expected_samples.size();
  end

endmodule

// File: verif/tb_adc_scan_frame_assembler_top.sv
// Testbench top for the ADC scan frame assembler: clock, reset, stimulus,
// random flow control and the verdict. Depends on adcsfa_pkg, the block and
// adcsfa_frame_checker.
module tb_adc_scan_frame_assembler_top;
  import adcsfa_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 750;
  localparam int HOLD_CYCLES = 150;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int fail_count;
  int outstanding;

  // Stimulus-side copy of the lane keys, used to build well-formed scans.
  logic [SELECT_W-1:0] lane_key[SELECT_REGS];
  int                  lanes_now  = 0;
  int                  counted    = 0;
  int                  tx_burst   = 0;
  logic [TIME_W-1:0]   stamp_us   = '0;
  logic                want_hold  = 1'b0;
  logic                hold_taken = 1'b0;
  int                  idle_cycles = 0;

  always #5 clk = ~clk;

  adc_scan_frame_assembler_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  adcsfa_frame_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Wait before the next item; now and then a run of back-to-back items.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    stamp_us = stamp_us + $urandom_range(1, 5000);
    return stamp_us;
  endfunction

  function automatic bit key_mapped(input logic [SELECT_W-1:0] key);
    int i;
    for (i = 0; i < lanes_now; i++) begin
      if (lane_key[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Leaves cfg_we high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] lane_cnt,
                           input logic [CFG_DATA_W-1:0] slot_cnt,
                           input logic [SELECT_W-1:0] key0, input logic [SELECT_W-1:0] key1,
                           input logic [SELECT_W-1:0] key2, input logic [SELECT_W-1:0] key3);
    write_reg(REG_LANE_COUNT, lane_cnt);
    write_reg(REG_SLOTS, slot_cnt);
    write_reg(REG_LANE0_SEL, CFG_DATA_W'(key0));
    write_reg(REG_LANE1_SEL, CFG_DATA_W'(key1));
    write_reg(REG_LANE2_SEL, CFG_DATA_W'(key2));
    write_reg(REG_LANE3_SEL, CFG_DATA_W'(key3));
    cfg_we      <= 1'b0;
    lane_key[0] = key0;
    lane_key[1] = key1;
    lane_key[2] = key2;
    lane_key[3] = key3;
    lanes_now   = (lane_cnt > MAX_LANES) ? MAX_LANES : lane_cnt;
  endtask

  task automatic send_item(input logic ok, input logic [SELECT_W-1:0] key,
                           input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] now);
    int                   gap;
    logic [IN_DATA_W-1:0] word;
    gap  = draw_gap(tx_burst);
    word = '0;
    word[IN_DATA_BITS-1:0] = {now, raw, key[CHANNEL_W-1:0], key[CHANNEL_W]};
    if (ok && key_mapped(key)) counted++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= ok;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Stops offering, waits for every expected item and lets the block settle.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int rounds);
    int r;
    int l;
    int pick;
    for (r = 0; r < rounds; r++) begin
      if (lanes_now == 0 || $urandom_range(0, 7) == 0) begin
        send_item(1'($urandom_range(0, 1)), SELECT_W'($urandom_range(0, 31)),
                  RAW_W'($urandom), next_stamp());
      end else begin
        // One scan round in lane order, now and then with a lane swapped,
        // skipped or marked invalid.
        for (l = 0; l < lanes_now; l++) begin
          pick = l;
          if ($urandom_range(0, 24) == 0) pick = $urandom_range(0, lanes_now - 1);
          if ($urandom_range(0, 39) != 0) begin
            send_item($urandom_range(0, 39) != 0, lane_key[pick], RAW_W'($urandom),
                      next_stamp());
          end
        end
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int gap;
    int rx_burst;
    rx_burst = 0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(rx_burst);
      if (want_hold && !hold_taken) begin
        gap        = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL adc_scan_frame_assembler_top");
      $finish;
    end
  end

  initial begin
    int                  p;
    int                  i;
    int                  rounds;
    logic [LANE_CNT_W-1:0] lane_cnt;
    logic [SLOTS_W-1:0]  slot_cnt;
    logic [SELECT_W-1:0] keys[SELECT_REGS];

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Two lanes, two slots: drops, value extremes, a full frame, then a restart
    // on a repeated lane 0 and an abort on a repeated lane 1.
    configure(7'd2, 7'd2, 5'd5, 5'd31, 5'd17, 5'd5);
    send_item(1'b0, 5'd5, 16'h1234, 64'd10);
    send_item(1'b1, 5'd31, 16'h1234, 64'd11);
    send_item(1'b1, 5'd17, 16'h1234, 64'd12);
    send_item(1'b1, 5'd5, 16'h0000, '1);
    send_item(1'b1, 5'd31, 16'hFFFF, '0);
    send_item(1'b1, 5'd5, 16'h0800, 64'd20);
    send_item(1'b1, 5'd31, 16'hF7FF, 64'd21);
    send_item(1'b1, 5'd31, 16'h0001, 64'd22);
    send_item(1'b1, 5'd5, 16'h5555, 64'h5555_5555_5555_5555);
    send_item(1'b1, 5'd5, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(1'b1, 5'd31, 16'h0FFF, 64'd30);
    send_item(1'b1, 5'd31, 16'h0FFE, 64'd31);
    finish_phase();

    // No lanes in use: everything is dropped.
    configure(7'd0, 7'd0, 5'd5, 5'd31, 5'd17, 5'd5);
    send_item(1'b1, 5'd5, 16'h0123, 64'd40);
    send_item(1'b1, 5'd31, 16'h0456, 64'd41);
    finish_phase();

    // Lane count above four saturates and zero slots act as one.
    configure(7'd7, 7'd0, 5'd0, 5'd16, 5'd15, 5'd31);
    for (i = 0; i < 2 * MAX_LANES; i++) begin
      send_item(1'b1, lane_key[i % MAX_LANES], RAW_W'($urandom), next_stamp());
    end
    finish_phase();

    for (p = 0; counted < ITEM_TARGET; p++) begin
      for (i = 0; i < SELECT_REGS; i++) keys[i] = SELECT_W'($urandom_range(0, 31));
      if ($urandom_range(0, 3) == 0) keys[3] = keys[1];
      if (p == 0) begin
        lane_cnt = 3'd1;
        slot_cnt = 7'd127;
      end else if (p == 2) begin
        lane_cnt = 3'd3;
        slot_cnt = 7'd3;
        keys[0]  = 5'd2;
        keys[1]  = 5'd18;
        keys[2]  = 5'd9;
      end else begin
        case ($urandom_range(0, 9))
          0:       lane_cnt = 3'd0;
          1:       lane_cnt = LANE_CNT_W'($urandom_range(5, 7));
          default: lane_cnt = LANE_CNT_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
          0:       slot_cnt = 7'd0;
          1:       slot_cnt = 7'd64;
          2:       slot_cnt = SLOTS_W'($urandom_range(65, 127));
          default: slot_cnt = SLOTS_W'($urandom_range(1, 4));
        endcase
      end
      rounds = (slot_cnt >= MAX_SLOTS) ? 80 : $urandom_range(15, 40);
      configure(CFG_DATA_W'(lane_cnt), CFG_DATA_W'(slot_cnt), keys[0], keys[1], keys[2],
                keys[3]);
      if (p == 2) want_hold <= 1'b1;
      random_phase(rounds);
      finish_phase();
    end

    if (fail_count == 0) begin
      $display("PASS adc_scan_frame_assembler_top");
    end else begin
      $display("FAIL adc_scan_frame_assembler_top");
    end
    $finish;
  end

endmodule
